// ===== src/four_level_page_table_walker_core_defines.svh =====
// Assertion macros used by the page table walker core.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTW_ASSERT(lbl, prop, msg)
`define PTW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/ptw_pkg.sv =====
package ptw_pkg;

  localparam logic [63:0] ROOT_MASK  = 64'hffff_ffff_ffff_f000;
  localparam logic [63:0] ENTRY_MASK = 64'h7fff_ffff_ffff_f000;
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned FRAME_W = 51;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 120;

  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_DIR  = 2'd2;
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef enum logic {
    MODE_TRANSLATE = 1'b0,
    MODE_RESPONSE  = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]      level;
    logic [VA_W-1:0] held_address;
    logic            busy;
  } walk_state_t;

  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  read_address;
    logic               mapped;
    logic               large_page;
    logic [FRAME_W-1:0] phys_frame;
  } walk_result_t;

endpackage

// ===== src/four_level_page_table_walker_core.sv =====
// Walks a four-level page table one step per request: a translate request
// issues the read of the top-level entry, and each read response either issues
// the next read or finishes the walk (not present, large page at level two,
// or final frame). A request may be accepted every cycle unless the result
// register is held by a stalled output; its result passes the input register
// and then the result register. The walk state register, updated as each
// request leaves the input register, carries the dependency from one request
// to the next. A response arriving while no walk is open is consumed without a
// result, and root_table_base should only be written while no walk is in progress.
`include "four_level_page_table_walker_core_defines.svh"

module four_level_page_table_walker_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ptw_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // virtual_address [47:0], read_data [111:48]
  input  logic [ptw_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // mode [0]
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // read_address [63:0], mapped [64], large_page [65], phys_frame [116:66], zero [119:117]
  output logic [ptw_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // kind [0]
  output logic                                 m_axis_tuser_o
);
  import ptw_pkg::*;

  logic               in_valid_q, in_valid_d;
  mode_e              in_mode_q;
  logic [VA_W-1:0]    in_va_q;
  logic [DATA_W-1:0]  in_rd_q;
  logic [DATA_W-1:0]  root_q;
  walk_state_t        state_q, state_d;
  logic               out_valid_q, out_valid_d;
  walk_result_t       out_res_q;
  walk_result_t       step_res;
  logic               step_res_valid;
  logic               step_en;

  assign step_en         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step_en;

  ptw_step u_step (
    .mode_i            (in_mode_q),
    .virtual_address_i (in_va_q),
    .read_data_i       (in_rd_q),
    .root_table_base_i (root_q),
    .state_i           (state_q),
    .state_o           (state_d),
    .result_valid_o    (step_res_valid),
    .result_o          (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = step_res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      state_q     <= '{level: LEVEL_TOP, held_address: '0, busy: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (step_en) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_mode_q <= mode_e'(s_axis_tuser_i);
      in_va_q   <= s_axis_tdata_i[VA_W-1:0];
      in_rd_q   <= s_axis_tdata_i[VA_W+DATA_W-1:VA_W];
    end
    if (step_en && step_res_valid) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tdata_o  = {3'd0, out_res_q.phys_frame, out_res_q.large_page,
                            out_res_q.mapped, out_res_q.read_address};

  `PTW_ASSERT(a_large_implies_mapped, m_axis_tvalid_o && out_res_q.large_page |-> out_res_q.mapped, "large page result without a mapping")
  `PTW_ASSERT(a_unmapped_frame_zero, m_axis_tvalid_o && out_res_q.kind == KIND_DONE && !out_res_q.mapped |-> out_res_q.phys_frame == '0, "unmapped result carries a frame")
  `PTW_ASSERT(a_read_fields_zero, m_axis_tvalid_o && out_res_q.kind == KIND_READ |-> !out_res_q.mapped && out_res_q.phys_frame == '0, "read request carries translation fields")
  `PTW_ASSERT(a_done_closes_walk, step_en && step_res_valid && step_res.kind == KIND_DONE |=> !state_q.busy, "walk still open after a finished translation")
  `PTW_ASSERT_ALWAYS(a_stall_only_when_full, !s_axis_tready_o |-> in_valid_q, "input stalled with an empty input register")

endmodule

// ===== src/ptw_step.sv =====
module ptw_step (
  input  ptw_pkg::mode_e                 mode_i,
  input  logic [ptw_pkg::VA_W-1:0]       virtual_address_i,
  input  logic [ptw_pkg::DATA_W-1:0]     read_data_i,
  input  logic [ptw_pkg::DATA_W-1:0]     root_table_base_i,
  input  ptw_pkg::walk_state_t           state_i,
  output ptw_pkg::walk_state_t           state_o,
  output logic                           result_valid_o,
  output ptw_pkg::walk_result_t          result_o
);
  import ptw_pkg::*;

  function automatic logic [DATA_W-1:0] entry_offset(input logic [1:0] lvl,
                                                      input logic [VA_W-1:0] va);
    logic [8:0] idx;
    case (lvl)
      2'd0: begin
        idx = va[47:39];
      end
      2'd1: begin
        idx = va[38:30];
      end
      2'd2: begin
        idx = va[29:21];
      end
      default: begin
        idx = va[20:12];
      end
    endcase
    return {52'd0, idx, 3'd0};
  endfunction

  logic [DATA_W-1:0] entry_base;
  logic [1:0]        next_level;

  assign entry_base = read_data_i & ENTRY_MASK;
  assign next_level = state_i.level + 2'd1;

  always_comb begin
    state_o        = state_i;
    result_valid_o = 1'b0;
    result_o       = '{kind: KIND_READ, read_address: '0, mapped: 1'b0,
                       large_page: 1'b0, phys_frame: '0};
    case (mode_i)
      MODE_TRANSLATE: begin
        state_o.held_address  = virtual_address_i;
        state_o.level         = LEVEL_TOP;
        state_o.busy          = 1'b1;
        result_valid_o        = 1'b1;
        result_o.read_address = (root_table_base_i & ROOT_MASK)
                                + entry_offset(LEVEL_TOP, virtual_address_i);
      end
      MODE_RESPONSE: begin
        if (state_i.busy) begin
          result_valid_o = 1'b1;
          if (!read_data_i[PRESENT_BIT]) begin
            state_o.busy  = 1'b0;
            result_o.kind = KIND_DONE;
          end else if ((state_i.level == LEVEL_DIR && read_data_i[LARGE_BIT])
                       || state_i.level == LEVEL_LAST) begin
            state_o.busy          = 1'b0;
            result_o.kind         = KIND_DONE;
            result_o.mapped       = 1'b1;
            result_o.large_page   = (state_i.level == LEVEL_DIR);
            result_o.phys_frame   = entry_base[62:12];
          end else begin
            state_o.level         = next_level;
            result_o.read_address = entry_base
                                    + entry_offset(next_level, state_i.held_address);
          end
        end
      end
      default: begin
        result_valid_o = 1'b0;
      end
    endcase
  end

endmodule
